// ===== rtl/gucc_pkg.sv =====
// gucc_pkg: shared types, codes and constants for the GPS / Unix / calendar converter.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none

package gucc_pkg;

   // Source form codes
   localparam logic [1:0] CMD_GPS  = 2'd0;
   localparam logic [1:0] CMD_UNIX = 2'd1;
   localparam logic [1:0] CMD_CAL  = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   // Time constants
   localparam logic [31:0] GPS_EPOCH_UNIX = 32'd315964800;
   localparam logic [19:0] SECS_PER_WEEK  = 20'd604800;
   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [33:0] LAST_UNIX_2099 = 34'd4102444799;
   localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
   localparam logic [11:0] YEAR_FIRST     = 12'd1970;
   localparam logic [11:0] YEAR_LAST      = 12'd2099;

   // Constant dividers: x / (D << S) = (x >> S) / D, quotient by reciprocal
   // (never high, at most one low), then one compare-and-subtract.
   localparam int          WEEK_SHIFT = 7;
   localparam logic [12:0] WEEK_DIV   = 13'd4725;
   localparam int          WEEK_K     = 26;
   localparam logic [13:0] WEEK_RECIP = 14'((64'd1 << WEEK_K) / 4725);

   localparam int          DAY_SHIFT  = 7;
   localparam logic [9:0]  DAY_DIV    = 10'd675;
   localparam int          DAY_K      = 26;
   localparam logic [16:0] DAY_RECIP  = 17'((64'd1 << DAY_K) / 675);

   localparam int          QUAD_K     = 17;
   localparam logic [6:0]  QUAD_RECIP = 7'((64'd1 << QUAD_K) / 1461);

   localparam int          HOUR_SHIFT = 4;
   localparam logic [7:0]  HOUR_DIV   = 8'd225;
   localparam int          HOUR_K     = 14;
   localparam logic [6:0]  HOUR_RECIP = 7'((64'd1 << HOUR_K) / 225);

   localparam int          MIN_SHIFT  = 2;
   localparam logic [3:0]  MIN_DIV    = 4'd15;
   localparam int          MIN_K      = 11;
   localparam logic [7:0]  MIN_RECIP  = 8'((64'd1 << MIN_K) / 15);

   // Front-to-back queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   typedef struct packed {
      logic [1:0]  cmd;
      logic [12:0] in_gps_week;
      logic [19:0] in_week_seconds;
      logic [31:0] in_unix_seconds;
      logic [11:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [4:0]  in_hour;
      logic [5:0]  in_minute;
      logic [5:0]  in_second;
      logic [31:0] in_fraction;
   } req_type;

   typedef struct packed {
      logic [12:0] out_gps_week;
      logic [19:0] out_week_seconds;
      logic [31:0] out_unix_seconds;
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic [31:0] out_fraction;
      logic        before_gps_epoch;
      logic        range_error;
   } rsp_type;

   // One queued item: whole Unix seconds plus what rides along
   typedef struct packed {
      logic [31:0] unix_seconds;
      logic        range_error;
      logic [31:0] fraction;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Zero-based day of year on which a month starts, common year
   function automatic logic [8:0] month_start(input logic [3:0] month);
      logic [8:0] r;
      case (month)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gucc_front.sv =====
// gucc_front: accepts items, sorts them by source form and forms whole Unix seconds.
// Depends on gucc_pkg; feeds gucc_queue.
`default_nettype none

module gucc_front
   import gucc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   input  wire req_type      req_data,
   output logic              req_full,
   input  wire q_status_type q_status,
   output logic              q_push,
   output item_type          q_item
);

   logic        adv;
   logic        valid_ff, valid_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [32:0] prod_ff, prod_in;
   logic [19:0] ws_ff, ws_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] hms_ff, hms_in;
   logic [31:0] unix_ff, unix_in;
   logic [31:0] frac_ff, frac_in;

   logic [11:0] yr;
   logic [7:0]  yo;
   logic [3:0]  mo;
   logic [4:0]  dy;
   logic        leap_adj;
   logic [33:0] gps_sum;
   logic [32:0] cal_sum;

   // the register moves whenever it is empty or its item can go into the queue
   assign adv      = !valid_ff || !q_status.full;
   assign req_full = !adv;

   // calendar fields clamped, then day count since 1970-01-01
   always_comb begin
      if (req_data.in_year < YEAR_FIRST) begin
         yr = YEAR_FIRST;
      end else if (req_data.in_year > YEAR_LAST) begin
         yr = YEAR_LAST;
      end else begin
         yr = req_data.in_year;
      end
      if (req_data.in_month == 4'd0) begin
         mo = 4'd1;
      end else if (req_data.in_month > 4'd12) begin
         mo = 4'd12;
      end else begin
         mo = req_data.in_month;
      end
      dy = (req_data.in_day == 5'd0) ? 5'd1 : req_data.in_day;
      yo = 8'(yr - YEAR_FIRST);
      // leap when year mod 4 is 0, i.e. two years past 1970 mod 4
      leap_adj = (yo[1:0] == 2'd2) && (mo >= 4'd3);
   end

   assign valid_in = adv ? (req_push && (req_data.cmd != CMD_NONE)) : valid_ff;
   assign cmd_in   = req_data.cmd;
   assign prod_in  = 33'(req_data.in_gps_week) * 33'(SECS_PER_WEEK);
   assign ws_in    = req_data.in_week_seconds;
   assign days_in  = 16'(yo) * 16'd365 + 16'((yo + 8'd1) >> 2) + 16'(month_start(mo))
                   + 16'(dy) - 16'd1 + 16'(leap_adj);
   assign hms_in   = 17'(req_data.in_hour) * 17'd3600 + 17'(req_data.in_minute) * 17'd60
                   + 17'(req_data.in_second);
   assign unix_in  = req_data.in_unix_seconds;
   assign frac_in  = req_data.in_fraction;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd_ff  <= cmd_in;
         prod_ff <= prod_in;
         ws_ff   <= ws_in;
         days_ff <= days_in;
         hms_ff  <= hms_in;
         unix_ff <= unix_in;
         frac_ff <= frac_in;
      end
   end

   assign gps_sum = 34'(prod_ff) + 34'(ws_ff) + 34'(GPS_EPOCH_UNIX);
   assign cal_sum = 33'(days_ff) * 33'(SECS_PER_DAY) + 33'(hms_ff);

   always_comb begin
      q_item.fraction = frac_ff;
      case (cmd_ff)
         CMD_GPS: begin
            q_item.unix_seconds = gps_sum[31:0];
            q_item.range_error  = gps_sum > LAST_UNIX_2099;
         end
         CMD_UNIX: begin
            q_item.unix_seconds = unix_ff;
            q_item.range_error  = 1'b0;
         end
         CMD_CAL: begin
            q_item.unix_seconds = cal_sum[31:0];
            q_item.range_error  = 1'b0;
         end
         default: begin
            q_item.unix_seconds = '0;
            q_item.range_error  = 1'b0;
         end
      endcase
   end

   assign q_push = valid_ff && !q_status.full;

endmodule

`default_nettype wire

// ===== rtl/gucc_queue.sv =====
// gucc_queue: short item queue between the front and the back.
// Depends on gucc_pkg.
`default_nettype none

module gucc_queue
   import gucc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      head_item,
   output q_status_type  status
);

   item_type           mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == (Q_PTR_W + 1)'(Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   // pointers wrap naturally: depth is a power of two
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = mem_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (Q_PTR_W + 1)'(Q_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      Q_PTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[Q_PTR_W-1:0])
      else $error("queue pointers disagree with count");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("item pushed into full queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/gucc_back.sv =====
// gucc_back: six-stage pipeline from Unix seconds to GPS week/seconds and calendar.
// Depends on gucc_pkg; drains gucc_queue, drives the result channel.
`default_nettype none

module gucc_back
   import gucc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire q_status_type q_status,
   input  wire item_type     q_item,
   output logic              q_pop,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output rsp_type           rsp_data
);

   typedef struct packed {
      logic [31:0] unix;
      logic        range;
      logic [31:0] frac;
      logic        pre_epoch;
      logic [31:0] g;
      logic [12:0] qw;
      logic [15:0] qd;
   } s1_type;

   typedef struct packed {
      logic [31:0] unix;
      logic        range;
      logic [31:0] frac;
      logic        pre_epoch;
      logic [12:0] week;
      logic [19:0] ws;
      logic [15:0] days;
      logic [16:0] rem;
   } s2_type;

   typedef struct packed {
      logic [31:0] unix;
      logic        range;
      logic [31:0] frac;
      logic        pre_epoch;
      logic [12:0] week;
      logic [19:0] ws;
      logic [15:0] days;
      logic [16:0] rem;
      logic [5:0]  quad;
      logic [4:0]  hour;
   } s3_type;

   typedef struct packed {
      logic [31:0] unix;
      logic        range;
      logic [31:0] frac;
      logic        pre_epoch;
      logic [12:0] week;
      logic [19:0] ws;
      logic [5:0]  quad;
      logic [10:0] dq;
      logic [4:0]  hour;
      logic [11:0] rs;
   } s4_type;

   typedef struct packed {
      logic [31:0] unix;
      logic        range;
      logic [31:0] frac;
      logic        pre_epoch;
      logic [12:0] week;
      logic [19:0] ws;
      logic [5:0]  quad;
      logic [1:0]  yq;
      logic [8:0]  doy;
      logic        leap;
      logic [4:0]  hour;
      logic [11:0] rs;
      logic [5:0]  minute;
   } s5_type;

   function automatic logic [10:0] year_start(input logic [1:0] yq);
      logic [10:0] r;
      case (yq)
         2'd0:    r = 11'd0;
         2'd1:    r = 11'd365;
         2'd2:    r = 11'd730;
         2'd3:    r = 11'd1096;
         default: r = 11'd0;
      endcase
      return r;
   endfunction

   logic        adv;
   logic [5:0]  valid_ff, valid_in;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   s5_type      s5_ff, s5_in;
   rsp_type     rsp_ff, rsp_in;

   logic [24:0] xw1, xd1;
   logic [38:0] pw;
   logic [41:0] pd;
   logic [24:0] rw_full, rd_full;
   logic [13:0] rw;
   logic [10:0] rd;
   logic        fix_w, fix_d;
   logic [22:0] pq;
   logic [19:0] ph;
   logic [15:0] dq_full;
   logic [11:0] dq;
   logic [12:0] rh_full;
   logic [8:0]  rh;
   logic        fix_q, fix_h;
   logic [17:0] pm;
   logic [9:0]  rm_full;
   logic [4:0]  rm;
   logic        fix_m;
   logic [3:0]  mi;
   logic [8:0]  mstart;

   // one advance for the whole pipe; a waiting result freezes it
   assign adv       = !valid_ff[5] || rsp_pop;
   assign q_pop     = adv && !q_status.empty;
   assign rsp_empty = !valid_ff[5];
   assign rsp_data  = rsp_ff;
   assign valid_in  = adv ? {valid_ff[4:0], !q_status.empty} : valid_ff;

   // stage 1: GPS offset, reciprocal estimates of week and day counts
   always_comb begin
      s1_in.unix      = q_item.unix_seconds;
      s1_in.range     = q_item.range_error;
      s1_in.frac      = q_item.fraction;
      s1_in.pre_epoch = q_item.unix_seconds < GPS_EPOCH_UNIX;
      s1_in.g         = s1_in.pre_epoch ? '0 : q_item.unix_seconds - GPS_EPOCH_UNIX;
      xw1             = s1_in.g[31:WEEK_SHIFT];
      xd1             = q_item.unix_seconds[31:DAY_SHIFT];
      pw              = 39'(xw1) * 39'(WEEK_RECIP);
      pd              = 42'(xd1) * 42'(DAY_RECIP);
      s1_in.qw        = pw[38:WEEK_K];
      s1_in.qd        = pd[41:DAY_K];
   end

   // stage 2: remainders, one correction step each
   always_comb begin
      rw_full         = s1_ff.g[31:WEEK_SHIFT] - 25'(s1_ff.qw) * 25'(WEEK_DIV);
      rw              = rw_full[13:0];
      fix_w           = rw >= 14'(WEEK_DIV);
      rd_full         = s1_ff.unix[31:DAY_SHIFT] - 25'(s1_ff.qd) * 25'(DAY_DIV);
      rd              = rd_full[10:0];
      fix_d           = rd >= 11'(DAY_DIV);
      s2_in.unix      = s1_ff.unix;
      s2_in.range     = s1_ff.range;
      s2_in.frac      = s1_ff.frac;
      s2_in.pre_epoch = s1_ff.pre_epoch;
      s2_in.week      = s1_ff.qw + 13'(fix_w);
      s2_in.ws        = {13'(fix_w ? rw - 14'(WEEK_DIV) : rw), s1_ff.g[WEEK_SHIFT-1:0]};
      s2_in.days      = s1_ff.qd + 16'(fix_d);
      s2_in.rem       = {10'(fix_d ? rd - 11'(DAY_DIV) : rd), s1_ff.unix[DAY_SHIFT-1:0]};
   end

   // stage 3: estimates of four-year block and hour
   always_comb begin
      pq              = 23'(s2_ff.days) * 23'(QUAD_RECIP);
      ph              = 20'(s2_ff.rem[16:HOUR_SHIFT]) * 20'(HOUR_RECIP);
      s3_in.unix      = s2_ff.unix;
      s3_in.range     = s2_ff.range;
      s3_in.frac      = s2_ff.frac;
      s3_in.pre_epoch = s2_ff.pre_epoch;
      s3_in.week      = s2_ff.week;
      s3_in.ws        = s2_ff.ws;
      s3_in.days      = s2_ff.days;
      s3_in.rem       = s2_ff.rem;
      s3_in.quad      = pq[22:QUAD_K];
      s3_in.hour      = ph[18:HOUR_K];
   end

   // stage 4: day within block, seconds within hour
   always_comb begin
      dq_full         = s3_ff.days - 16'(s3_ff.quad) * 16'(DAYS_PER_QUAD);
      dq              = dq_full[11:0];
      fix_q           = dq >= 12'(DAYS_PER_QUAD);
      rh_full         = s3_ff.rem[16:HOUR_SHIFT] - 13'(s3_ff.hour) * 13'(HOUR_DIV);
      rh              = rh_full[8:0];
      fix_h           = rh >= 9'(HOUR_DIV);
      s4_in.unix      = s3_ff.unix;
      s4_in.range     = s3_ff.range;
      s4_in.frac      = s3_ff.frac;
      s4_in.pre_epoch = s3_ff.pre_epoch;
      s4_in.week      = s3_ff.week;
      s4_in.ws        = s3_ff.ws;
      s4_in.quad      = s3_ff.quad + 6'(fix_q);
      s4_in.dq        = 11'(fix_q ? dq - 12'(DAYS_PER_QUAD) : dq);
      s4_in.hour      = s3_ff.hour + 5'(fix_h);
      s4_in.rs        = {8'(fix_h ? rh - 9'(HOUR_DIV) : rh), s3_ff.rem[HOUR_SHIFT-1:0]};
   end

   // stage 5: year within block (third one is leap), minute estimate
   always_comb begin
      pm              = 18'(s4_ff.rs[11:MIN_SHIFT]) * 18'(MIN_RECIP);
      s5_in.unix      = s4_ff.unix;
      s5_in.range     = s4_ff.range;
      s5_in.frac      = s4_ff.frac;
      s5_in.pre_epoch = s4_ff.pre_epoch;
      s5_in.week      = s4_ff.week;
      s5_in.ws        = s4_ff.ws;
      s5_in.quad      = s4_ff.quad;
      s5_in.yq        = 2'(s4_ff.dq >= 11'd365) + 2'(s4_ff.dq >= 11'd730)
                      + 2'(s4_ff.dq >= 11'd1096);
      s5_in.doy       = 9'(s4_ff.dq - year_start(s5_in.yq));
      s5_in.leap      = (s5_in.yq == 2'd2);
      s5_in.hour      = s4_ff.hour;
      s5_in.rs        = s4_ff.rs;
      s5_in.minute    = pm[16:MIN_K];
   end

   // stage 6: month and day, minute and second, final result
   always_comb begin
      mi = '0;
      for (int k = 1; k < 12; k++) begin
         if (s5_ff.doy >= month_start(4'(k + 1)) + 9'(s5_ff.leap && (k >= 2))) begin
            mi = mi + 4'd1;
         end
      end
      mstart  = month_start(mi + 4'd1) + 9'(s5_ff.leap && (mi >= 4'd2));
      rm_full = s5_ff.rs[11:MIN_SHIFT] - 10'(s5_ff.minute) * 10'(MIN_DIV);
      rm      = rm_full[4:0];
      fix_m   = rm >= 5'(MIN_DIV);

      if (s5_ff.range) begin
         rsp_in             = '0;
         rsp_in.range_error = 1'b1;
      end else begin
         rsp_in.out_gps_week     = s5_ff.week;
         rsp_in.out_week_seconds = s5_ff.ws;
         rsp_in.out_unix_seconds = s5_ff.unix;
         rsp_in.out_year         = YEAR_FIRST + 12'({s5_ff.quad, 2'b00}) + 12'(s5_ff.yq);
         rsp_in.out_month        = mi + 4'd1;
         rsp_in.out_day          = 5'(s5_ff.doy - mstart + 9'd1);
         rsp_in.out_hour         = s5_ff.hour;
         rsp_in.out_minute       = s5_ff.minute + 6'(fix_m);
         rsp_in.out_second       = {4'(fix_m ? rm - 5'(MIN_DIV) : rm),
                                    s5_ff.rs[MIN_SHIFT-1:0]};
         rsp_in.out_fraction     = s5_ff.frac;
         rsp_in.before_gps_epoch = s5_ff.pre_epoch;
         rsp_in.range_error      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gps_unix_calendar_time_converter_core.sv =====
// gps_unix_calendar_time_converter_core: top level, front + queue + back.
// Depends on gucc_pkg, gucc_front, gucc_queue, gucc_back.
// Throughput: one item per cycle, set by the back pipeline's single advance signal;
//    a pending result stalls the back, the 4-entry queue keeps the front accepting.
// Reset (synchronous, high): clears valid bits, queue pointers and count; no sweep.
`default_nettype none

module gps_unix_calendar_time_converter_core
   import gucc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // input channel: accepted when req_push && !req_full
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   // result channel: oldest result shown while !rsp_empty, taken on rsp_pop
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   // Front: one register stage. At accept it clamps the calendar fields and
   // forms the day count and hour/minute/second sum, and the GPS week product.
   // From that register it picks the Unix seconds by source form and flags
   // GPS inputs past 2099. Items with the unused selector are taken and
   // dropped here, so they give no result.
   //
   // Queue: four entries of {Unix seconds, range flag, fraction}. The front
   // pushes a held item while the queue has room; the back pops when it advances.
   //
   // Back: six stages, all moved by one advance (result register free or
   // being taken). Constant divisions are reciprocal multiplies with one
   // correction each, split so every stage has one multiply per lane:
   //    1 week and day estimates   2 week/day remainders
   //    3 four-year and hour est.  4 day in block, seconds in hour
   //    5 year in block, minute    6 month/day, seconds, result register
   // Times before the GPS epoch give zero week and seconds and a flag; a
   // range error zeroes every field but the flag.

   q_status_type q_status;
   logic         q_push;
   logic         q_pop;
   item_type     q_push_item;
   item_type     q_head_item;

   gucc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_status (q_status),
      .q_push   (q_push),
      .q_item   (q_push_item)
   );

   gucc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .status    (q_status)
   );

   gucc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_item    (q_head_item),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== test/gps_unix_calendar_time_converter_core_tb.sv =====
// Testbench for gps_unix_calendar_time_converter_core: directed and random time items
// in all three source forms, checked against an in-bench converter. Needs gucc_pkg and the core.
`timescale 1ns / 1ps

module gps_unix_calendar_time_converter_core_tb
   import gucc_pkg::*;
();

   // Conversion constants, kept apart from the RTL package on purpose
   localparam longint unsigned EPOCH_SECS  = 64'd315964800;
   localparam longint unsigned WEEK_SECS   = 64'd604800;
   localparam longint unsigned DAY_SECS    = 64'd86400;
   localparam longint unsigned QUAD_DAYS   = 64'd1461;
   localparam longint unsigned LAST_SECS   = 64'd4102444799;

   localparam int RANDOM_ITEMS = 800;
   localparam int MAX_GAP      = 16;
   localparam int HOLD_AFTER   = 100;   // results seen before the long receiver hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;    // drain slack after the last result, for strays
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on either side

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   gps_unix_calendar_time_converter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   req_type     pending_items[$];   // filled up front, drained by the driver
   rsp_type     expected_times[$];  // one entry per accepted item that makes a result
   int unsigned total_items    = 0;
   int unsigned items_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned fails          = 0;
   int unsigned stall_cycles   = 0;

   // Handshake outcomes seen at the last rising edge, read by the falling-edge drivers
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Converter: returns 0 for the unused selector, else fills the expected result.
   function automatic bit predict_time(input req_type r, output rsp_type o);
      int unsigned month_first[12] = '{1, 32, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};
      int unsigned month_days[12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      longint unsigned secs, g, days, rem, quad, d, y, m, dd, len;
      int unsigned mon;
      o = '0;
      case (r.cmd)
         CMD_NONE: return 1'b0;
         CMD_GPS: begin
            secs = longint'(r.in_gps_week) * WEEK_SECS + longint'(r.in_week_seconds)
                 + EPOCH_SECS;
            // Past the end of 2099: everything zero but the flag, fraction too
            if (secs > LAST_SECS) begin
               o.range_error = 1'b1;
               return 1'b1;
            end
         end
         CMD_UNIX: secs = longint'(r.in_unix_seconds);
         default: begin
            // Date fields clamp, time-of-day fields roll forward as given
            y  = r.in_year;
            y  = (y < 1970) ? 1970 : (y > 2099) ? 2099 : y;
            m  = r.in_month;
            m  = (m < 1) ? 1 : (m > 12) ? 12 : m;
            dd = r.in_day;
            dd = (dd < 1) ? 1 : dd;
            days = (y - 1970) * 365 + (y - 1969) / 4 + month_first[m - 1] + dd - 2;
            if ((y % 4) == 0 && m >= 3) days++;
            secs = days * DAY_SECS + longint'(r.in_hour) * 3600
                 + longint'(r.in_minute) * 60 + longint'(r.in_second);
         end
      endcase
      secs &= 64'hFFFF_FFFF;

      if (secs < EPOCH_SECS) begin
         o.before_gps_epoch = 1'b1;
      end else begin
         g = secs - EPOCH_SECS;
         o.out_gps_week     = 13'(g / WEEK_SECS);
         o.out_week_seconds = 20'(g % WEEK_SECS);
      end
      o.out_unix_seconds = secs[31:0];

      // Walk months through a four-year cycle; third year of the cycle is leap
      days = secs / DAY_SECS;
      rem  = secs % DAY_SECS;
      quad = days / QUAD_DAYS;
      d    = days % QUAD_DAYS;
      mon  = 0;
      len  = 31;
      while (mon < 47 && d >= len) begin
         d -= len;
         mon++;
         len = (mon % 12 == 1) ? ((mon / 12 == 2) ? 29 : 28) : month_days[mon % 12];
      end
      o.out_year     = 12'(1970 + quad * 4 + mon / 12);
      o.out_month    = 4'(mon % 12 + 1);
      o.out_day      = 5'(d + 1);
      o.out_hour     = 5'(rem / 3600);
      o.out_minute   = 6'((rem % 3600) / 60);
      o.out_second   = 6'(rem % 60);
      o.out_fraction = r.in_fraction;
      return 1'b1;
   endfunction

   // Random filler everywhere; the builders then set the fields the source form uses
   function automatic req_type noise_item();
      req_type r;
      r.cmd             = 2'($urandom);
      r.in_gps_week     = 13'($urandom);
      r.in_week_seconds = 20'($urandom);
      r.in_unix_seconds = $urandom;
      r.in_year         = 12'($urandom);
      r.in_month        = 4'($urandom);
      r.in_day          = 5'($urandom);
      r.in_hour         = 5'($urandom);
      r.in_minute       = 6'($urandom);
      r.in_second       = 6'($urandom);
      r.in_fraction     = $urandom;
      return r;
   endfunction

   function automatic req_type gps_item(int unsigned week, int unsigned wsec);
      req_type r;
      r = noise_item();
      r.cmd             = CMD_GPS;
      r.in_gps_week     = 13'(week);
      r.in_week_seconds = 20'(wsec);
      return r;
   endfunction

   function automatic req_type unix_item(int unsigned secs);
      req_type r;
      r = noise_item();
      r.cmd             = CMD_UNIX;
      r.in_unix_seconds = secs;
      return r;
   endfunction

   function automatic req_type cal_item(int unsigned yr, int unsigned mo, int unsigned dy,
                                        int unsigned hr, int unsigned mi, int unsigned sc);
      req_type r;
      r = noise_item();
      r.cmd       = CMD_CAL;
      r.in_year   = 12'(yr);
      r.in_month  = 4'(mo);
      r.in_day    = 5'(dy);
      r.in_hour   = 5'(hr);
      r.in_minute = 6'(mi);
      r.in_second = 6'(sc);
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   // Append one item to the stimulus list
   task automatic add_item(req_type r);
      pending_items.insert(pending_items.size(), r);
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: one item per handshake, random gap before each, with calm stretches of no gap
   // ---------------------------------------------------------------------------------------
   int unsigned send_gap = 0;
   bit          send_calm = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && req_taken) begin
            void'(pending_items.pop_front());
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (req_push && !req_taken) begin
            // offered but not taken: hold item and push steady
         end else if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items[0];
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: random wait after each item taken, and one long hold-off so the core's
   // queue fills and it pushes back on the driver
   // ---------------------------------------------------------------------------------------
   int unsigned pop_wait  = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   bit          pop_calm  = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) pop_calm = !pop_calm;
            pop_wait = pop_calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: results are checked before the same edge's new item is predicted, so a stray
   // result can never pair up with an item accepted on that very edge
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_push && !req_full;
         rsp_taken <= rsp_pop && !rsp_empty;
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_times.size() == 0) begin
               $error("result with no item waiting: %p", rsp_data);
               fails++;
            end else begin
               want = expected_times.pop_front();
               check_field("out_gps_week",     want.out_gps_week,     rsp_data.out_gps_week);
               check_field("out_week_seconds", want.out_week_seconds, rsp_data.out_week_seconds);
               check_field("out_unix_seconds", want.out_unix_seconds, rsp_data.out_unix_seconds);
               check_field("out_year",         want.out_year,         rsp_data.out_year);
               check_field("out_month",        want.out_month,        rsp_data.out_month);
               check_field("out_day",          want.out_day,          rsp_data.out_day);
               check_field("out_hour",         want.out_hour,         rsp_data.out_hour);
               check_field("out_minute",       want.out_minute,       rsp_data.out_minute);
               check_field("out_second",       want.out_second,       rsp_data.out_second);
               check_field("out_fraction",     want.out_fraction,     rsp_data.out_fraction);
               check_field("before_gps_epoch", want.before_gps_epoch, rsp_data.before_gps_epoch);
               check_field("range_error",      want.range_error,      rsp_data.range_error);
            end
         end
         if (req_push && !req_full) begin
            items_accepted++;
            if (predict_time(req_data, want))
               expected_times.insert(expected_times.size(), want);
         end
      end
   end

   // Watchdog: a long run of edges with no handshake at all means the core is stuck
   always @(posedge clock) begin
      if (!reset && !(req_push && !req_full) && !(rsp_pop && !rsp_empty)) begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end else begin
         stall_cycles = 0;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------------------
   initial begin
      req_type     it;
      int unsigned useful;
      int unsigned sel;

      // Directed: epoch, week-second overflow, last GPS second of 2099 and one past it
      it = gps_item(0, 0);
      it.in_fraction = 32'h0000_0000;
      add_item(it);
      it = gps_item(0, 20'hFFFFF);
      it.in_fraction = 32'hFFFF_FFFF;
      add_item(it);
      add_item(gps_item(6260, 431999));
      add_item(gps_item(6260, 432000));
      add_item(gps_item(13'h1FFF, 20'hFFFFF));
      add_item(gps_item(1000, 604799));
      // Unix: zero, either side of the GPS epoch, end of 2099 and beyond it (2100 is leap here)
      add_item(unix_item(0));
      add_item(unix_item(32'd315964799));
      add_item(unix_item(32'd315964800));
      add_item(unix_item(32'd4102444799));
      add_item(unix_item(32'd4102444800));
      add_item(unix_item(32'd4107542400));   // 2100-02-29 in a leap-2100 world
      add_item(unix_item(32'hFFFF_FFFF));
      // Calendar: range ends, leap day, GPS epoch and the last second of 1979
      add_item(cal_item(1970, 1, 1, 0, 0, 0));
      add_item(cal_item(2099, 12, 31, 23, 59, 59));
      add_item(cal_item(2000, 2, 29, 12, 0, 0));
      add_item(cal_item(1980, 1, 6, 0, 0, 0));
      add_item(cal_item(1979, 12, 31, 23, 59, 59));
      // Clamped date fields, and time fields that roll over into the next day
      add_item(cal_item(0, 0, 0, 0, 0, 0));
      add_item(cal_item(12'hFFF, 4'hF, 31, 31, 63, 63));
      add_item(cal_item(2021, 2, 31, 0, 0, 0));
      add_item(cal_item(2023, 12, 31, 31, 0, 0));
      // Unused selector: swallowed, no result
      it = noise_item();
      it.cmd = CMD_NONE;
      add_item(it);

      // Random: mostly well-formed items, some raw bits in every field
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         it  = noise_item();
         sel = $urandom_range(0, 99);
         if (sel < 3) begin
            it.cmd = CMD_NONE;
         end else begin
            useful++;
            it.cmd = 2'($urandom_range(0, 2));
            if (sel >= 20) begin
               case (it.cmd)
                  CMD_GPS: begin
                     it.in_gps_week     = 13'($urandom_range(0, 6261));
                     it.in_week_seconds = 20'($urandom_range(0, 604799));
                  end
                  CMD_UNIX: begin
                     if ($urandom_range(0, 3) == 0)
                        it.in_unix_seconds = $urandom_range(32'd315864800, 32'd316064800);
                     else
                        it.in_unix_seconds = $urandom_range(0, 32'd4102444799);
                  end
                  default: begin
                     it.in_year   = 12'($urandom_range(1970, 2099));
                     it.in_month  = 4'($urandom_range(1, 12));
                     it.in_day    = 5'($urandom_range(1, 31));
                     it.in_hour   = 5'($urandom_range(0, 23));
                     it.in_minute = 6'($urandom_range(0, 59));
                     it.in_second = 6'($urandom_range(0, 59));
                  end
               endcase
            end
         end
         add_item(it);
      end
      total_items = pending_items.size();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Every item in and every result out, then a drain wait for strays
      while (!(items_accepted == total_items && expected_times.size() == 0))
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gucc_pkg.sv
rtl/gucc_front.sv
rtl/gucc_queue.sv
rtl/gucc_back.sv
rtl/gps_unix_calendar_time_converter_core.sv
test/gps_unix_calendar_time_converter_core_tb.sv
